// ----- hw/rtl/fpmc_pkg.sv -----
// shared types and constants for the flash program memory controller
`default_nettype none

package fpmc_pkg;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] REG_ADDR = 2'd0;
  localparam logic [1:0] REG_DATA = 2'd1;
  localparam logic [1:0] REG_CTRL = 2'd2;
  localparam logic [1:0] REG_KEY  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  localparam logic [1:0] UNLOCK_NONE = 2'd0;
  localparam logic [1:0] UNLOCK_HALF = 2'd1;
  localparam logic [1:0] UNLOCK_DONE = 2'd2;

  localparam logic [11:0] KEY_FIRST  = 12'h055;
  localparam logic [11:0] KEY_SECOND = 12'h0AA;

  // bit positions in a control write
  localparam int CTRL_READ_BIT  = 0;
  localparam int CTRL_WRITE_BIT = 1;

  // bit positions in the stored control bits
  localparam int CB_ENABLE     = 0;
  localparam int CB_ERASE      = 1;
  localparam int CB_LATCH_ONLY = 2;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef struct packed {
    logic        do_erase;
    logic        do_latch;
    logic        do_program;
    logic        do_read;
    logic        refused;
    logic [11:0] addr;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       load;
    logic [7:0] data;
    logic [1:0] status;
  } done_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fpmc_queue.sv -----
// two-entry command queue between the register front and the array sequencer
`default_nettype none

module fpmc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fpmc_pkg::cmd_t push_cmd,
  input  logic           pop,
  output fpmc_pkg::cmd_t pop_cmd,
  output logic           empty,
  output logic           full
);
  import fpmc_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fpmc_back.sv -----
// array sequencer: clearing pass, erase, latch load, row program and byte read
`default_nettype none

module fpmc_back #(
  parameter int ARRAY_BYTES     = 4096,
  parameter int ERASE_ROW_BYTES = 32,
  parameter int WRITE_ROW_BYTES = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fpmc_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            clearing,
  output fpmc_pkg::done_t done
);
  import fpmc_pkg::*;

  localparam int AW = $clog2(ARRAY_BYTES);
  localparam int WW = $clog2(WRITE_ROW_BYTES);
  localparam logic [AW-1:0] ARRAY_LAST = AW'(ARRAY_BYTES - 1);
  localparam logic [AW-1:0] ERASE_LAST = AW'(ERASE_ROW_BYTES - 1);
  localparam logic [AW-1:0] WRITE_LAST = AW'(WRITE_ROW_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ERASE,
    S_LATCH,
    S_PROG,
    S_PROG_END,
    S_READ,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  state_t                     state_r;
  cmd_t                       cmd_r;
  logic [AW-1:0]              cnt_r;
  done_t                      done_r;
  logic                       prog_wr_r;
  logic [AW-1:0]              prog_wa_r;
  logic [WRITE_ROW_BYTES-1:0] lat_vld_r;
  logic                       lat_q_vld_r;
  logic [7:0]                 lat_q_r;
  logic [7:0]                 fl_rdata_r;

  logic [7:0] flash_mem [ARRAY_BYTES];
  logic [7:0] lat_mem   [WRITE_ROW_BYTES];

  logic [AW+11:0] addr_ext;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  erase_base;
  logic [AW-1:0]  prog_base;
  logic [WW-1:0]  lat_idx;
  logic [WW-1:0]  lat_rd_idx;
  logic           fl_we;
  logic [AW-1:0]  fl_waddr;
  logic [7:0]     fl_wdata;
  logic           lat_we;
  logic [1:0]     op_status;

  assign addr_ext   = {{AW{1'b0}}, cmd_r.addr};
  assign idx        = addr_ext[AW-1:0];
  assign erase_base = idx & ~ERASE_LAST;
  assign prog_base  = idx & ~WRITE_LAST;
  assign lat_idx    = idx[WW-1:0];
  assign lat_rd_idx = cnt_r[WW-1:0];
  assign lat_we     = (state_r == S_LATCH);
  assign op_status  = cmd_r.refused ? ST_REFUSED : ST_DONE;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign clearing = (state_r == S_CLEAR);
  assign done     = done_r;

  always_comb begin
    fl_we    = 1'b0;
    fl_waddr = cnt_r;
    fl_wdata = ERASED_BYTE;
    if (state_r == S_CLEAR) begin
      fl_we = 1'b1;
    end else if (state_r == S_ERASE) begin
      fl_we    = 1'b1;
      fl_waddr = erase_base | cnt_r;
    end else if (prog_wr_r) begin
      fl_we    = 1'b1;
      fl_waddr = prog_wa_r;
      fl_wdata = lat_q_vld_r ? lat_q_r : ERASED_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flash_mem[fl_waddr] <= fl_wdata;
    end
    fl_rdata_r <= flash_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (lat_we) begin
      lat_mem[lat_idx] <= cmd_r.data;
    end
    lat_q_r <= lat_mem[lat_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      done_r.valid <= 1'b0;
      prog_wr_r    <= 1'b0;
      lat_vld_r    <= '0;
    end else begin
      done_r.valid <= (state_r == S_READ_WAIT) || (state_r == S_FINISH);
      prog_wr_r    <= (state_r == S_PROG);
      prog_wa_r    <= prog_base | cnt_r;
      lat_q_vld_r  <= lat_vld_r[lat_rd_idx];
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == ARRAY_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_cmd;
            cnt_r <= '0;
            if (q_cmd.do_erase) begin
              state_r <= S_ERASE;
            end else if (q_cmd.do_latch) begin
              state_r <= S_LATCH;
            end else if (q_cmd.do_read) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_ERASE: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == ERASE_LAST) begin
            state_r <= cmd_r.do_read ? S_READ : S_FINISH;
          end
        end
        S_LATCH: begin
          lat_vld_r[lat_idx] <= 1'b1;
          cnt_r              <= '0;
          if (cmd_r.do_program) begin
            state_r <= S_PROG;
          end else begin
            state_r <= cmd_r.do_read ? S_READ : S_FINISH;
          end
        end
        S_PROG: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == WRITE_LAST) begin
            state_r <= S_PROG_END;
          end
        end
        S_PROG_END: begin
          lat_vld_r <= '0;
          state_r   <= cmd_r.do_read ? S_READ : S_FINISH;
        end
        S_READ: begin
          state_r <= S_READ_WAIT;
        end
        S_READ_WAIT: begin
          done_r.load   <= 1'b1;
          done_r.data   <= fl_rdata_r;
          done_r.status <= op_status;
          state_r       <= S_IDLE;
        end
        S_FINISH: begin
          done_r.load   <= 1'b0;
          done_r.data   <= fl_rdata_r;
          done_r.status <= op_status;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != S_IDLE))
    else $error("queue pop did not start an operation");

  a_no_done_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !done_r.valid)
    else $error("completion during clearing pass");

  a_latches_clear_after_prog: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROG_END) |=> (lat_vld_r == '0))
    else $error("write latches not reset after row program");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/fpmc_front.sv -----
// register front end: decodes accesses, keeps the host registers, issues array commands
`default_nettype none

module fpmc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            in_req_type,
  input  logic [1:0]      in_reg_index,
  input  logic [11:0]     in_write_data,
  output logic            out_valid,
  output logic [11:0]     out_read_data,
  output logic [1:0]      out_status,
  input  logic            back_clearing,
  output logic            q_push,
  output fpmc_pkg::cmd_t  q_cmd,
  input  fpmc_pkg::done_t done
);
  import fpmc_pkg::*;

  logic [11:0] address_r, address_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [2:0]  ctrl_r, ctrl_nxt;
  logic [1:0]  unlock_r, unlock_nxt;
  logic        pending_r, pending_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] out_rdata_r, out_rdata_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic       accept;
  logic [2:0] ctrl_new;
  logic       wr_req;
  logic       rd_req;
  logic       wr_ok;

  assign busy          = pending_r || back_clearing;
  assign accept        = start && !busy;
  assign ctrl_new      = in_write_data[4:2];
  assign wr_req        = in_write_data[CTRL_WRITE_BIT];
  assign rd_req        = in_write_data[CTRL_READ_BIT];
  assign wr_ok         = ctrl_new[CB_ENABLE] && (unlock_r == UNLOCK_DONE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rdata_r;
  assign out_status    = out_status_r;

  always_comb begin
    address_nxt    = address_r;
    data_nxt       = data_r;
    ctrl_nxt       = ctrl_r;
    unlock_nxt     = unlock_r;
    pending_nxt    = pending_r;
    out_valid_nxt  = 1'b0;
    out_rdata_nxt  = '0;
    out_status_nxt = ST_OK;
    q_push         = 1'b0;
    q_cmd          = '0;

    if (done.valid) begin
      pending_nxt    = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = done.status;
      if (done.load) begin
        data_nxt = done.data;
      end
    end

    if (accept) begin
      if (in_req_type == REQ_READ) begin
        out_valid_nxt = 1'b1;
        unique case (in_reg_index)
          REG_ADDR: out_rdata_nxt = address_r;
          REG_DATA: out_rdata_nxt = {4'b0, data_r};
          REG_CTRL: out_rdata_nxt = {7'b0, ctrl_r, 2'b00};
          default:  out_rdata_nxt = '0;
        endcase
      end else begin
        unlock_nxt = UNLOCK_NONE;
        unique case (in_reg_index)
          REG_ADDR: begin
            address_nxt   = in_write_data;
            out_valid_nxt = 1'b1;
          end
          REG_DATA: begin
            data_nxt      = in_write_data[7:0];
            out_valid_nxt = 1'b1;
          end
          REG_CTRL: begin
            ctrl_nxt         = ctrl_new;
            q_cmd.do_erase   = wr_req && wr_ok && ctrl_new[CB_ERASE];
            q_cmd.do_latch   = wr_req && wr_ok && !ctrl_new[CB_ERASE];
            q_cmd.do_program = wr_req && wr_ok && !ctrl_new[CB_ERASE]
                               && !ctrl_new[CB_LATCH_ONLY];
            q_cmd.do_read    = rd_req;
            q_cmd.refused    = wr_req && !wr_ok;
            q_cmd.addr       = address_r;
            q_cmd.data       = data_r;
            if ((wr_req && wr_ok) || rd_req) begin
              q_push      = 1'b1;
              pending_nxt = 1'b1;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = wr_req ? ST_REFUSED : ST_OK;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            if (in_write_data == KEY_FIRST) begin
              unlock_nxt = UNLOCK_HALF;
            end else if (in_write_data == KEY_SECOND && unlock_r == UNLOCK_HALF) begin
              unlock_nxt = UNLOCK_DONE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r   <= '0;
      data_r      <= '0;
      ctrl_r      <= '0;
      unlock_r    <= UNLOCK_NONE;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      address_r   <= address_nxt;
      data_r      <= data_nxt;
      ctrl_r      <= ctrl_nxt;
      unlock_r    <= unlock_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rdata_r  <= out_rdata_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_done_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> pending_r)
    else $error("completion without an outstanding command");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |=> (out_valid && out_status != ST_OK))
    else $error("completion not reported");

  a_write_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_data == '0))
    else $error("nonzero read data on a control result");

  a_unlock_code: assert property (@(posedge clk) disable iff (!rst_n)
    unlock_r != 2'd3)
    else $error("unlock progress out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/flash_program_memory_controller.sv -----
// top level of the flash program memory controller
// results: register reads, address/data/key writes and refused writes without a read
//   request give a result in the cycle after the transfer; a control read, latch load,
//   erase or row program gives its result once the array sequencer has finished it
// throughput: array commands go one at a time; busy stays high until its result has been given
// reset: a clearing pass sets every array byte to 0xFF, with busy high
// the result strobe cannot be stalled by the receiver
`default_nettype none

module flash_program_memory_controller #(
  parameter int ARRAY_BYTES     = 4096,
  parameter int ERASE_ROW_BYTES = 32,
  parameter int WRITE_ROW_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [1:0]  in_reg_index,
  input  logic [11:0] in_write_data,
  output logic        out_valid,
  output logic [11:0] out_read_data,
  output logic [1:0]  out_status
);
  import fpmc_pkg::*;

  cmd_t  push_cmd;
  cmd_t  pop_cmd;
  done_t done;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;
  logic  clearing;

  fpmc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_reg_index  (in_reg_index),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .back_clearing (clearing),
    .q_push        (push),
    .q_cmd         (push_cmd),
    .done          (done)
  );

  fpmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  fpmc_back #(
    .ARRAY_BYTES     (ARRAY_BYTES),
    .ERASE_ROW_BYTES (ERASE_ROW_BYTES),
    .WRITE_ROW_BYTES (WRITE_ROW_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .clearing (clearing),
    .done     (done)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  a_busy_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy)
    else $error("not busy during clearing pass");

  a_push_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> busy)
    else $error("not busy after issuing a command");
`endif

endmodule

`default_nettype wire
